// ===== design/mtvb_pkg.sv =====
package mtvb_pkg;

	localparam int VEC_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF = 16;
	localparam int LIMIT_WIDTH = 16;
	localparam int WEIGHT_WIDTH = 17;
	localparam int CFG_DATA_WIDTH = 16;
	localparam int CFG_INDEX_WIDTH = 1;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [0:0] {
		CFG_DIRECTION_MODE = 1'b0,
		CFG_ZERO_LENGTH_LIMIT = 1'b1
	} cfg_index_t;

	typedef enum logic [0:0] {
		ACT_BIND = 1'b0,
		ACT_DELTA = 1'b1
	} action_t;

	// back-end sequencer
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SQ,
		BK_ROOT,
		BK_CHECK,
		BK_DIV,
		BK_DONE
	} bk_state_t;

	// flags that travel with a queued vertex
	typedef struct packed {
		logic direction;
		logic saturated;
	} vtx_flags_t;

endpackage

// ===== design/mtvb_front.sv =====
module mtvb_front #(
	parameter int VEC_WIDTH = mtvb_pkg::VEC_WIDTH_DEF,
	parameter int FRAC_BITS = mtvb_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    action,
	input  logic signed [VEC_WIDTH-1:0]             vec_x,
	input  logic signed [VEC_WIDTH-1:0]             vec_y,
	input  logic signed [VEC_WIDTH-1:0]             vec_z,
	input  logic [mtvb_pkg::WEIGHT_WIDTH-1:0]       weight,
	input  logic                                    last,
	input  logic                                    direction_mode,
	output logic                                    push,
	input  logic                                    full,
	output logic [6*VEC_WIDTH-1:0]                  push_vecs,
	output mtvb_pkg::vtx_flags_t                    push_flags
);

	localparam int WW = mtvb_pkg::WEIGHT_WIDTH;
	localparam int PW = VEC_WIDTH + WW + 1;
	localparam int AW = PW + 2;
	localparam logic signed [AW-1:0] VMAX_A = AW'((longint'(1) <<< (VEC_WIDTH-1)) - 1);
	localparam logic signed [AW-1:0] VMIN_A = -VMAX_A - AW'(1);
	localparam logic signed [PW-1:0] HALF = PW'(longint'(1) <<< (FRAC_BITS-1));

	logic signed [VEC_WIDTH-1:0] acc_q [3];
	logic signed [VEC_WIDTH-1:0] bind_q [3];
	logic                        clip_q;

	// stage 1: registered product of a delta item
	logic                        busy_s1;
	logic                        last_s1;
	logic signed [PW-1:0]        prod_s1 [3];

	logic [WW-1:0]               w_sat;
	logic signed [VEC_WIDTH-1:0] vin [3];
	logic signed [VEC_WIDTH-1:0] acc_n [3];
	logic                        clip_n;
	logic                        take;
	logic                        bind_last_q;

	assign vin[0] = vec_x;
	assign vin[1] = vec_y;
	assign vin[2] = vec_z;
	assign w_sat = (weight > WW'(65536)) ? WW'(65536) : weight;
	// a last item needs queue room when it completes; hold off while a bind push is pending
	assign in_ready = !busy_s1 && !bind_last_q && !(last && full);
	assign take = in_valid && in_ready;

	always_comb begin
		logic signed [PW-1:0] r;
		logic signed [AW-1:0] s;
		clip_n = clip_q;
		for (int i = 0; i < 3; i++) begin
			r = (prod_s1[i] + HALF) >>> FRAC_BITS;
			s = AW'(acc_q[i]) + AW'(r);
			if (s > VMAX_A) begin
				acc_n[i] = VEC_WIDTH'(VMAX_A);
				clip_n = 1'b1;
			end else if (s < VMIN_A) begin
				acc_n[i] = VEC_WIDTH'(VMIN_A);
				clip_n = 1'b1;
			end else begin
				acc_n[i] = VEC_WIDTH'(s);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			clip_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
				bind_q[i] <= '0;
			end
		end else begin
			if (busy_s1) begin
				busy_s1 <= 1'b0;
				clip_q <= clip_n;
				for (int i = 0; i < 3; i++) acc_q[i] <= acc_n[i];
			end
			if (take && action == mtvb_pkg::ACT_BIND) begin
				clip_q <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					acc_q[i] <= vin[i];
					bind_q[i] <= vin[i];
				end
			end else if (take) begin
				busy_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			last_s1 <= last;
			for (int i = 0; i < 3; i++)
				prod_s1[i] <= PW'(vin[i]) * $signed({1'b0, w_sat});
		end
	end

	// bind items push from a registered flag; deltas push during their add stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bind_last_q <= 1'b0;
		else bind_last_q <= take && action == mtvb_pkg::ACT_BIND && last;
	end

	assign push = bind_last_q || (busy_s1 && last_s1);
	always_comb begin
		push_vecs = '0;
		for (int i = 0; i < 3; i++) begin
			push_vecs[i*VEC_WIDTH +: VEC_WIDTH] = bind_last_q ? acc_q[i] : acc_n[i];
			push_vecs[(i+3)*VEC_WIDTH +: VEC_WIDTH] = bind_q[i];
		end
		push_flags.direction = direction_mode;
		push_flags.saturated = bind_last_q ? clip_q : clip_n;
	end

endmodule

// ===== design/mtvb_queue.sv =====
module mtvb_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mtvb_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [IW-1:0]    wr_q, rd_q;
	logic [IW:0]      cnt_q;

	assign full = cnt_q == (IW+1)'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == IW'(DEPTH-1)) ? '0 : wr_q + IW'(1);
			if (pop) rd_q <= (rd_q == IW'(DEPTH-1)) ? '0 : rd_q + IW'(1);
			cnt_q <= cnt_q + (IW+1)'(push) - (IW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

// ===== design/mtvb_back.sv =====
module mtvb_back #(
	parameter int VEC_WIDTH = mtvb_pkg::VEC_WIDTH_DEF,
	parameter int FRAC_BITS = mtvb_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  job_valid,
	output logic                                  job_pop,
	input  logic [6*VEC_WIDTH-1:0]                job_vecs,
	input  mtvb_pkg::vtx_flags_t                  job_flags,
	input  logic [mtvb_pkg::LIMIT_WIDTH-1:0]      zero_length_limit,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [VEC_WIDTH-1:0]           out_x,
	output logic signed [VEC_WIDTH-1:0]           out_y,
	output logic signed [VEC_WIDTH-1:0]           out_z,
	output logic                                  used_fallback,
	output logic                                  degenerate,
	output logic                                  saturated
);

	localparam int MW = VEC_WIDTH;                   // magnitude width
	localparam int SW = 2*MW + 2;                    // sum of squares
	localparam int RW = SW/2 + 1;                    // root width
	localparam int RCW = $clog2(RW + 1);
	localparam int NW = MW + FRAC_BITS;              // dividend width
	localparam int QW = NW + 1;
	localparam int QCW = $clog2(QW + 1);
	localparam logic [QW-1:0] QMAX = QW'((longint'(1) <<< (VEC_WIDTH-1)) - 1);

	mtvb_pkg::bk_state_t state_q, state_n;

	logic [MW-1:0]  mag_q [3];
	logic           neg_q [3];
	logic [MW-1:0]  bmag_q [3];
	logic           bneg_q [3];
	logic           fb_q, dg_q, dir_q, sat_q;
	logic [1:0]     idx_q;
	logic [SW-1:0]  sq_q;
	logic [2*MW-1:0] prod_s1;
	logic           prod_v_s1;
	logic [SW-1:0]  rem_q;
	logic [RW-1:0]  root_q;
	logic [RCW-1:0] rcnt_q;
	logic [QW+RW:0] drem_q;
	logic [QW-1:0]  quo_q;
	logic [QCW-1:0] dcnt_q;
	logic [QW-1:0]  num_w;
	logic signed [VEC_WIDTH-1:0] res_q [3];
	logic           obusy_q;

	// degenerate check and restoring division step
	logic           deg_w;
	logic [QW+RW:0] d_shift;
	logic [QW+RW:0] d_sub;

	assign job_pop = state_q == mtvb_pkg::BK_IDLE && job_valid && !obusy_q;
	assign out_valid = obusy_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			mtvb_pkg::BK_IDLE:
				if (job_pop) state_n = job_flags.direction ? mtvb_pkg::BK_SQ
					: mtvb_pkg::BK_DONE;
			mtvb_pkg::BK_SQ:
				if (prod_v_s1 && idx_q == 2'd2) state_n = mtvb_pkg::BK_ROOT;
			mtvb_pkg::BK_ROOT:
				if (rcnt_q == RCW'(1)) state_n = mtvb_pkg::BK_CHECK;
			mtvb_pkg::BK_CHECK:
				// too short: retry with the bind vector, or give up on the second try
				if (!deg_w) state_n = mtvb_pkg::BK_DIV;
				else if (fb_q) state_n = mtvb_pkg::BK_DONE;
				else state_n = mtvb_pkg::BK_SQ;
			mtvb_pkg::BK_DIV:
				if (dcnt_q == QCW'(1) && idx_q == 2'd2) state_n = mtvb_pkg::BK_DONE;
			mtvb_pkg::BK_DONE:
				state_n = mtvb_pkg::BK_IDLE;
			default: state_n = mtvb_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		deg_w = root_q <= RW'(zero_length_limit);
		num_w = QW'({mag_q[idx_q], FRAC_BITS'(0)}) + QW'(root_q >> 1);
		d_shift = {drem_q[QW+RW-1:0], num_w[dcnt_q-QCW'(1)]};
		d_sub = d_shift - (QW+RW+1)'(root_q);
	end

	logic [SW-1:0] sq_top;
	assign sq_top = sq_q >> (2*(rcnt_q-RCW'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtvb_pkg::BK_IDLE;
			obusy_q <= 1'b0;
			prod_v_s1 <= 1'b0;
		end else begin
			state_q <= state_n;
			prod_v_s1 <= state_q == mtvb_pkg::BK_SQ && !prod_v_s1;
			if (state_q == mtvb_pkg::BK_DONE) obusy_q <= 1'b1;
			else if (out_ready) obusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		logic [SW-1:0] rr;
		logic [SW-1:0] tt;
		unique case (state_q)
			mtvb_pkg::BK_IDLE: if (job_pop) begin
				dir_q <= job_flags.direction;
				sat_q <= job_flags.saturated;
				fb_q <= 1'b0;
				dg_q <= 1'b0;
				idx_q <= '0;
				sq_q <= '0;
				for (int i = 0; i < 3; i++) begin
					logic signed [VEC_WIDTH-1:0] a, b;
					a = job_vecs[i*VEC_WIDTH +: VEC_WIDTH];
					b = job_vecs[(i+3)*VEC_WIDTH +: VEC_WIDTH];
					neg_q[i] <= a[VEC_WIDTH-1];
					mag_q[i] <= a[VEC_WIDTH-1] ? MW'(-a) : MW'(a);
					bneg_q[i] <= b[VEC_WIDTH-1];
					bmag_q[i] <= b[VEC_WIDTH-1] ? MW'(-b) : MW'(b);
					res_q[i] <= a;
				end
			end
			mtvb_pkg::BK_SQ: begin
				if (!prod_v_s1) begin
					prod_s1 <= mag_q[idx_q] * mag_q[idx_q];
				end else begin
					sq_q <= sq_q + SW'(prod_s1);
					if (idx_q == 2'd2) begin
						idx_q <= '0;
						rem_q <= '0;
						root_q <= '0;
						rcnt_q <= RCW'(SW/2);
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
			end
			mtvb_pkg::BK_ROOT: begin
				rr = {rem_q[SW-3:0], sq_top[1:0]};
				tt = SW'({root_q, 2'b01});
				if (rr >= tt) begin
					rem_q <= rr - tt;
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q <= rr;
					root_q <= {root_q[RW-2:0], 1'b0};
				end
				rcnt_q <= rcnt_q - RCW'(1);
			end
			mtvb_pkg::BK_CHECK: begin
				idx_q <= '0;
				drem_q <= '0;
				quo_q <= '0;
				dcnt_q <= QCW'(NW + RW + 1 > QW ? QW : NW + RW + 1);
				if (deg_w) begin
					if (fb_q) begin
						// bind too short: emit zero
						dg_q <= 1'b1;
						for (int i = 0; i < 3; i++) res_q[i] <= '0;
					end else begin
						fb_q <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= bmag_q[i];
							neg_q[i] <= bneg_q[i];
						end
						sq_q <= '0;
					end
				end
			end
			mtvb_pkg::BK_DIV: begin
				if (d_shift >= (QW+RW+1)'(root_q)) begin
					drem_q <= d_sub;
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					drem_q <= d_shift;
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q - QCW'(1);
				if (dcnt_q == QCW'(1)) begin
					logic [QW-1:0] q;
					q = (d_shift >= (QW+RW+1)'(root_q)) ? {quo_q[QW-2:0], 1'b1}
						: {quo_q[QW-2:0], 1'b0};
					if (q > QMAX) q = QMAX;
					res_q[idx_q] <= neg_q[idx_q] ? -VEC_WIDTH'(q) : VEC_WIDTH'(q);
					idx_q <= idx_q + 2'd1;
					drem_q <= '0;
					quo_q <= '0;
					dcnt_q <= QCW'(QW);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == mtvb_pkg::BK_DONE) begin
			out_x <= res_q[0];
			out_y <= res_q[1];
			out_z <= res_q[2];
			used_fallback <= dir_q & fb_q;
			degenerate <= dir_q & dg_q;
			saturated <= sat_q;
		end
	end

endmodule

// ===== design/morph_target_vector_blend.sv =====
// Morph target blender. A vertex opens with a bind item (action 0) and each
// delta item (action 1) adds vec*weight, rounded, into a saturating Q7.16
// accumulator; the item with last set yields one result. Bind items can be
// taken back to back, while a delta item (multiply, then round and add)
// holds off the input until its add is done, since there is a single
// accumulator; a bind item with last set also holds off the input while its
// vector is pushed to the queue, and a last item waits while the queue is
// full. In position mode a result passes from the queue through the back
// end's idle and done states to the registered outputs. In direction mode a
// sequential unit squares the components (multiply, then accumulate), takes
// a bit-per-cycle square root and divides each component one bit per cycle;
// the bind fallback adds another squaring and root pass. A two-entry queue
// lets new vertices enter while that runs.
module morph_target_vector_blend #(
	parameter int VEC_WIDTH = mtvb_pkg::VEC_WIDTH_DEF,
	parameter int FRAC_BITS = mtvb_pkg::FRAC_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [mtvb_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  logic [mtvb_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic                                     action,
	input  logic signed [VEC_WIDTH-1:0]              vec_x,
	input  logic signed [VEC_WIDTH-1:0]              vec_y,
	input  logic signed [VEC_WIDTH-1:0]              vec_z,
	input  logic [mtvb_pkg::WEIGHT_WIDTH-1:0]        weight,
	input  logic                                     last,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [VEC_WIDTH-1:0]              out_x,
	output logic signed [VEC_WIDTH-1:0]              out_y,
	output logic signed [VEC_WIDTH-1:0]              out_z,
	output logic                                     used_fallback,
	output logic                                     degenerate,
	output logic                                     saturated
);

	localparam int QWID = 6*VEC_WIDTH + $bits(mtvb_pkg::vtx_flags_t);

	logic                                 dir_q;
	logic [mtvb_pkg::LIMIT_WIDTH-1:0]     limit_q;
	logic                                 push, full, q_valid, pop;
	logic [6*VEC_WIDTH-1:0]               push_vecs, pop_vecs;
	mtvb_pkg::vtx_flags_t                 push_flags, pop_flags;
	logic [QWID-1:0]                      pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
			limit_q <= mtvb_pkg::LIMIT_WIDTH'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				mtvb_pkg::CFG_DIRECTION_MODE: dir_q <= cfg_data[0];
				mtvb_pkg::CFG_ZERO_LENGTH_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mtvb_front #(.VEC_WIDTH(VEC_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .action, .vec_x, .vec_y, .vec_z,
		.weight, .last, .direction_mode(dir_q), .push, .full, .push_vecs, .push_flags
	);

	mtvb_queue #(.WIDTH(QWID), .DEPTH(mtvb_pkg::QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push, .push_data({push_flags, push_vecs}), .full,
		.pop, .not_empty(q_valid), .pop_data
	);

	assign pop_vecs = pop_data[6*VEC_WIDTH-1:0];
	assign pop_flags = pop_data[QWID-1:6*VEC_WIDTH];

	mtvb_back #(.VEC_WIDTH(VEC_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .job_valid(q_valid), .job_pop(pop), .job_vecs(pop_vecs),
		.job_flags(pop_flags), .zero_length_limit(limit_q), .out_valid, .out_ready,
		.out_x, .out_y, .out_z, .used_fallback, .degenerate, .saturated
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("pop from empty queue");
	a_pos_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> used_fallback) else $error("degenerate without fallback");

endmodule
